### hdl/smx_pkg.sv
package smx_pkg;

  localparam int MaxChannels = 64;
  localparam int IdxW = $clog2(MaxChannels);
  localparam int CntW = IdxW + 1;
  localparam int SumW = 23;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_SUM_RD,
    ST_SUM_EXP,
    ST_SUM_ACC,
    ST_DIV_RD,
    ST_DIV_EXP,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_OUT
  } state_t;

  function automatic logic [15:0] exp_hi(input logic [3:0] n);
    logic [15:0] r;
    case (n)
      4'd0: r = 16'd65535;
      4'd1: r = 16'd24109;
      4'd2: r = 16'd8869;
      4'd3: r = 16'd3263;
      4'd4: r = 16'd1200;
      4'd5: r = 16'd442;
      4'd6: r = 16'd162;
      4'd7: r = 16'd60;
      4'd8: r = 16'd22;
      4'd9: r = 16'd8;
      4'd10: r = 16'd3;
      4'd11: r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // round(65536*e^(-f/256)); f = 0 handled as 65536 by caller
  function automatic logic [15:0] exp_lo(input logic [7:0] f);
    real v;
    v = 65536.0 * $exp(-$itor(f) / 256.0) + 0.5;
    return 16'($rtoi(v));
  endfunction

endpackage

### hdl/smx_exp.sv
module smx_exp (
  input  logic        clk,
  input  logic [15:0] d,
  output logic [16:0] e_r
);
  import smx_pkg::*;

  logic [16:0] hi, lo;
  logic [33:0] p;
  logic [16:0] e_nxt;
  logic [15:0] lo_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_lo
    assign lo_tab[g] = exp_lo(8'(g));
  end

  always_comb begin
    hi = (d[11:8] == 4'd0) ? 17'h10000 : {1'b0, exp_hi(d[11:8])};
    lo = (d[7:0] == 8'd0) ? 17'h10000 : {1'b0, lo_tab[d[7:0]]};
    p = hi * lo + 34'd32768;
    e_nxt = (d[15:12] != 4'd0) ? 17'd0 : p[32:16];
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end
endmodule

### hdl/softmax_vector_unit_top.sv
// Sequence: after the last logit of an N-logit vector is taken, a sum pass reads, exps and
// accumulates each logit in turn, then the first divide runs before out_tvalid rises.
// Input: logits are taken one per cycle while collecting; each result then goes through
// read, exp, load, divide and output, and no new logit is taken until the last is accepted.
// Reset: rst_n synchronous, active low; clears control, count, max and sum; length 2.
module softmax_vector_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,      // [6:0] channel_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [15:0] logit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [15:0] probability
  output logic        out_tlast
);
  import smx_pkg::*;

  state_t state_r, state_nxt;
  logic [6:0] len_r;
  logic [CntW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt, n_r, n_nxt;
  logic signed [15:0] max_r, max_nxt;
  logic [SumW-1:0] sum_r, sum_nxt;
  logic [15:0] mem [MaxChannels];
  logic [15:0] rd_r;
  logic [16:0] e_r;
  logic [15:0] d;
  logic [CntW-1:0] lenc;
  logic [39:0] rem_r, rem_nxt;
  logic [32:0] q_r, q_nxt;
  logic [5:0] step_r, step_nxt;
  logic [15:0] prob_r, prob_nxt;
  logic last_r, last_nxt;
  logic in_fire;
  logic [40:0] trial;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_COLLECT);
  assign in_fire = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = prob_r;
  assign out_tlast = last_r;

  always_comb begin
    if (len_r == 7'd0) lenc = CntW'(1);
    else if (len_r > 7'(MaxChannels)) lenc = CntW'(MaxChannels);
    else lenc = CntW'(len_r);
  end

  assign d = 16'($signed(max_r) - $signed(rd_r));

  smx_exp u_exp (.clk(clk), .d(d), .e_r(e_r));

  always_ff @(posedge clk) begin
    if (in_fire) mem[cnt_r[IdxW-1:0]] <= in_tdata;
    rd_r <= mem[idx_r[IdxW-1:0]];
  end

  assign trial = {rem_r, q_r[32]} - {18'd0, sum_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: if (in_fire && (cnt_r + CntW'(1) >= lenc)) state_nxt = ST_SUM_RD;
      ST_SUM_RD: state_nxt = ST_SUM_EXP;
      ST_SUM_EXP: state_nxt = ST_SUM_ACC;
      ST_SUM_ACC: state_nxt = (idx_r == n_r) ? ST_DIV_RD : ST_SUM_RD;
      ST_DIV_RD: state_nxt = ST_DIV_EXP;
      ST_DIV_EXP: state_nxt = ST_DIV_LD;
      ST_DIV_LD: state_nxt = ST_DIV_RUN;
      ST_DIV_RUN: if (step_r == 6'd33) state_nxt = ST_OUT;
      ST_OUT: if (out_tready) state_nxt = last_r ? ST_COLLECT : ST_DIV_RD;
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r; idx_nxt = idx_r; n_nxt = n_r; max_nxt = max_r;
    sum_nxt = sum_r; rem_nxt = rem_r; q_nxt = q_r; step_nxt = step_r;
    prob_nxt = prob_r; last_nxt = last_r;
    case (state_r)
      ST_COLLECT: if (in_fire) begin
        if (cnt_r == CntW'(0) || $signed(in_tdata) > max_r) max_nxt = in_tdata;
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_r + CntW'(1) >= lenc) begin
          n_nxt = cnt_r + CntW'(1);
          idx_nxt = '0;
          sum_nxt = '0;
          cnt_nxt = '0;
        end
      end
      ST_SUM_RD: idx_nxt = idx_r + CntW'(1);
      ST_SUM_ACC: begin
        sum_nxt = sum_r + SumW'(e_r);
        if (idx_r == n_r) idx_nxt = '0;
      end
      ST_DIV_RD: idx_nxt = idx_r + CntW'(1);
      ST_DIV_LD: begin
        rem_nxt = '0;
        q_nxt = {e_r, 16'd0};
        step_nxt = '0;
      end
      ST_DIV_RUN: begin
        if (step_r == 6'd33) begin
          if (sum_r == '0 || q_r[32:16] != 17'd0) prob_nxt = 16'hffff;
          else prob_nxt = q_r[15:0];
          last_nxt = (idx_r == n_r);
        end else begin
          step_nxt = step_r + 6'd1;
          if (!trial[40]) begin
            rem_nxt = trial[39:0];
            q_nxt = {q_r[31:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[38:0], q_r[32]};
            q_nxt = {q_r[31:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      len_r <= 7'd2;
      cnt_r <= '0; idx_r <= '0; n_r <= '0;
      max_r <= '0; sum_r <= '0;
      step_r <= '0; last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) len_r <= cfg_data[6:0];
      cnt_r <= cnt_nxt; idx_r <= idx_nxt; n_r <= n_nxt;
      max_r <= max_nxt; sum_r <= sum_nxt;
      step_r <= step_nxt; last_r <= last_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    prob_r <= prob_nxt;
  end

  // trial uses shifted-in dividend bit
endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import smx_pkg::*;

  localparam int IdleLimit = 20000;

  typedef struct {
    bit [15:0] prob;
    bit        last;
  } prob_exp_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  softmax_vector_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  logic [15:0] logit_q[$];
  prob_exp_t   prob_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_len = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;
  int          errors = 0;
  int          logits_sent = 0;
  int          probs_seen = 0;
  int          vectors_done = 0;
  int          idle_cycles = 0;

  // predictor state
  bit [6:0]    vec_len_reg = 7'd2;
  logic signed [15:0] logit_mem[MaxChannels];
  logic signed [15:0] max_logit = '0;
  int          logit_cnt = 0;
  bit [15:0]   lo_tab[256];
  bit [15:0]   hi_tab[16] = '{16'd65535, 24109, 8869, 3263, 1200, 442, 162, 60,
                              22, 8, 3, 1, 0, 0, 0, 0};

  function automatic bit [63:0] mul_q60(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = a * b;
    return p[123:60];
  endfunction

  function automatic bit [31:0] exp_fraction(int f);
    bit [63:0] x, term, pos, neg;
    x = 64'(f) << 52;
    term = 64'd1 << 60;
    pos = term;
    neg = 0;
    for (int k = 1; k <= 30; k++) begin
      term = mul_q60(term, x) / k;
      if (k % 2) neg += term;
      else pos += term;
    end
    return 32'(((pos - neg) + (64'd1 << 43)) >> 44);
  endfunction

  function automatic bit [31:0] exp_of_gap(int d);
    bit [63:0] p;
    if (d >= 4096) return 0;
    p = (d < 256 ? 64'd65536 : 64'(hi_tab[d >> 8])) * ((d % 256) == 0 ?
        64'd65536 : 64'(lo_tab[d % 256])) + 32768;
    return 32'(p >> 16);
  endfunction

  task automatic absorb_logit(logic signed [15:0] v);
    int len;
    bit [22:0] sum;
    bit [63:0] e, q;
    prob_exp_t r;
    len = vec_len_reg;
    if (len < 1) len = 1;
    if (len > MaxChannels) len = MaxChannels;
    if (logit_cnt >= MaxChannels) logit_cnt = 0;
    logit_mem[logit_cnt] = v;
    if (logit_cnt == 0 || v > max_logit) max_logit = v;
    logit_cnt++;
    if (logit_cnt < len) return;
    sum = 0;
    for (int i = 0; i < logit_cnt; i++) sum += 23'(exp_of_gap(int'(max_logit) - int'(logit_mem[i])));
    for (int i = 0; i < logit_cnt; i++) begin
      e = exp_of_gap(int'(max_logit) - int'(logit_mem[i]));
      q = 65535;
      if (sum != 0) begin
        q = (e << 16) / sum;
        if (q > 65535) q = 65535;
      end
      r.prob = q[15:0];
      r.last = (i + 1 == logit_cnt);
      prob_q.push_back(r);
    end
    logit_cnt = 0;
    vectors_done++;
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // logit driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_logit(in_tdata);
        logits_sent++;
      end
      if (in_tvalid && !in_tready) begin
      end else if (logit_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1;
        in_tdata <= logit_q.pop_front();
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_cnt <= hold_len;
      out_tready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    prob_exp_t x;
    if (rst_n && out_tvalid && out_tready) begin
      probs_seen++;
      if (prob_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer prob=%0d last=%0b", $time, out_tdata, out_tlast);
      end else begin
        x = prob_q.pop_front();
        if (out_tdata !== x.prob) begin
          errors++;
          $display("%0t: probability expected %0d actual %0d", $time, x.prob, out_tdata);
        end
        if (out_tlast !== x.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, x.last, out_tlast);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, prob_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain();
    do @(posedge clk);
    while (logit_q.size() > 0 || in_tvalid || prob_q.size() > 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_length(bit [6:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= {1'b0, v};
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    vec_len_reg = v;
    cfg_valid <= 0;
  endtask

  function automatic logic [15:0] rand_logit(logic signed [15:0] base, int spread);
    return 16'(int'(base) - $urandom_range(spread));
  endfunction

  task automatic push_vector(int n, int spread);
    logic signed [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < n; i++) logit_q.push_back(rand_logit(base, spread));
  endtask

  initial begin
    int spreads[4] = '{255, 1500, 4500, 65535};
    int pcts[4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{27, 27}};
    int n, sent_here;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = '0;
    for (int f = 0; f < 256; f++) lo_tab[f] = 16'(exp_fraction(f));
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: default length, extremes, equal logits, exp cut-off edges
    logit_q = '{16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'hffff, 16'h0001};
    drain();
    logit_q = '{16'd4095, 16'd0, 16'd4096, 16'd0};
    drain();
    set_length(7'd0);
    logit_q = '{16'h1234, 16'h8000};
    drain();
    set_length(7'd1);
    logit_q.push_back(16'h7fff);
    drain();
    set_length(7'd127);
    push_vector(64, 4500);
    drain();
    // length lowered mid-vector: next logit closes it
    set_length(7'd8);
    logit_q = '{16'h0100, 16'hff00, 16'h0080, 16'h0200, 16'h0000};
    drain();
    set_length(7'd3);
    logit_q.push_back(16'h0300);
    drain();

    // long receiver hold-off while the sender keeps offering
    set_length(7'd32);
    hold_len = 1500;
    hold_seq++;
    push_vector(32, 1500);
    push_vector(32, 65535);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pcts[ph][0];
      recv_stall_pct = pcts[ph][1];
      sent_here = 0;
      while (sent_here < 30) begin
        set_length($urandom_range(99) < 8 ? 7'($urandom_range(127)) :
                   7'($urandom_range(2, 8)));
        n = vec_len_reg < 1 ? 1 : (vec_len_reg > 64 ? 64 : vec_len_reg);
        for (int v = 0; v < 3 && sent_here < 30; v++) begin
          push_vector(n, spreads[$urandom_range(3)]);
          sent_here += n;
        end
        drain();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    $display("Covered %0d logits in %0d vectors, %0d probabilities checked,", logits_sent,
             vectors_done, probs_seen);
    $display("lengths 1..64 with clamping, mid-vector length change, stalls and hold-off.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/smx_pkg.sv
hdl/smx_exp.sv
hdl/softmax_vector_unit_top.sv
tb/tb.sv
